// ----- design/nsd_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence deframer package
// Byte class codes, queue entry type, event codes and the table of known
// sentence names shared by the front, queue and back of the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsd_pkg;

	// Class of one received byte, decided in the front.
	localparam logic [2:0] CL_OTHER  = 3'd0;
	localparam logic [2:0] CL_DOLLAR = 3'd1;
	localparam logic [2:0] CL_STAR   = 3'd2;
	localparam logic [2:0] CL_CR     = 3'd3;
	localparam logic [2:0] CL_LF     = 3'd4;
	localparam logic [2:0] CL_COMMA  = 3'd5;

	// Framing characters.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// Result event codes.
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_START   = 3'd1;
	localparam logic [2:0] EV_RESTART = 3'd2;
	localparam logic [2:0] EV_BYTE    = 3'd3;
	localparam logic [2:0] EV_SEP     = 3'd4;
	localparam logic [2:0] EV_ACCEPT  = 3'd5;
	localparam logic [2:0] EV_DROP    = 3'd6;
	localparam logic [2:0] EV_STRAY   = 3'd7;

	// Known sentence names, left-justified in 8 character slots.
	localparam int         KNOWN_COUNT  = 14;
	localparam logic [3:0] TYPE_UNKNOWN = 4'd14;
	localparam int         KNOWN_SLOTS  = 8;

	localparam logic [63:0] KNOWN_TEXT [KNOWN_COUNT] = '{
		{"GPGGA", 24'h0}, {"GPGLL", 24'h0}, {"GPGSA", 24'h0}, {"GPGSV", 24'h0},
		{"GPMSS", 24'h0}, {"GPRMC", 24'h0}, {"GPVTG", 24'h0}, {"GPZDA", 24'h0},
		{"PSRF140", 8'h0}, {"PSRF150", 8'h0}, {"PSRF151", 8'h0},
		{"PSRF152", 8'h0}, {"PSRF154", 8'h0}, {"PSRF155", 8'h0}
	};

	localparam logic [3:0] KNOWN_LEN [KNOWN_COUNT] = '{
		4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
		4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7
	};

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// One classified item waiting for the back.
	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] data;
	} nsd_entry_t;

endpackage

`default_nettype wire

// ----- design/nsd_if.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence deframer channels
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface nsd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [7:0]  data_byte;
	logic [4:0]  field_number;
	logic [3:0]  sentence_type;
	logic [15:0] checksum_text;

	modport source (output valid, output event_kind, output data_byte,
		output field_number, output sentence_type, output checksum_text,
		input ready);
	modport sink (input valid, input event_kind, input data_byte,
		input field_number, input sentence_type, input checksum_text,
		output ready);
endinterface

`default_nettype wire

// ----- design/nsd_front.sv -----
// ----------------------------------------------------------------------------
// NMEA deframer front
// Accepts received bytes and tags each with its framing class before it
// enters the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsd_front (
	nsd_in_if.sink               in,
	input  wire logic            q_full,
	output logic                 push,
	output nsd_pkg::nsd_entry_t  push_entry
);
	import nsd_pkg::*;

	// Take an item whenever the queue has room.
	assign in.ready = !q_full;
	assign push     = in.valid && !q_full;

	// Classify the byte by its framing role.
	always_comb begin
		push_entry.data = in.byte_in;
		case (in.byte_in)
			CH_DOLLAR: push_entry.cls = CL_DOLLAR;
			CH_STAR:   push_entry.cls = CL_STAR;
			CH_CR:     push_entry.cls = CL_CR;
			CH_LF:     push_entry.cls = CL_LF;
			CH_COMMA:  push_entry.cls = CL_COMMA;
			default:   push_entry.cls = CL_OTHER;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/nsd_queue.sv -----
// ----------------------------------------------------------------------------
// NMEA deframer queue
// Short first-in first-out queue of classified items between the front and
// the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire nsd_pkg::nsd_entry_t  push_entry,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      head_valid,
	output nsd_pkg::nsd_entry_t       head_entry
);
	import nsd_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	nsd_entry_t    slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/nsd_back.sv -----
// ----------------------------------------------------------------------------
// NMEA deframer back
// Runs the sentence framing state machine on classified items, keeps the
// sentence name, field counter and checksum, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsd_back #(
	parameter int MAX_FIELDS = 32,
	parameter int NAME_CHARS = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire nsd_pkg::nsd_entry_t  head_entry,
	output logic                      pop,
	nsd_out_if.source                 out
);
	import nsd_pkg::*;

	localparam int FIELD_TOP = ((MAX_FIELDS - 1) < 31) ? (MAX_FIELDS - 1) : 31;
	localparam int NI        = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
	localparam int NL        = $clog2(NAME_CHARS + 2);
	localparam int CMP_CHARS = (NAME_CHARS < KNOWN_SLOTS) ? NAME_CHARS : KNOWN_SLOTS;

	// Frame phases.
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_CK0  = 3'd2;
	localparam logic [2:0] PH_CK1  = 3'd3;
	localparam logic [2:0] PH_CR   = 3'd4;
	localparam logic [2:0] PH_LF   = 3'd5;

	logic [2:0]    phase_q, phase_d;
	logic [7:0]    name_q [NAME_CHARS];
	logic [NL-1:0] name_len_q, name_len_d;
	logic [4:0]    field_q, field_d;
	logic [15:0]   cksum_q, cksum_d;
	logic          name_wr;

	logic          out_valid_q;
	logic [2:0]    ev_q, ev_d;
	logic [7:0]    data_q, data_d;
	logic [3:0]    type_q, type_d;
	logic [3:0]    match_type;

	// Advance whenever the result register is free or being emptied.
	assign pop = head_valid && (!out_valid_q || out.ready);

	assign out.valid         = out_valid_q;
	assign out.event_kind    = ev_q;
	assign out.data_byte     = data_q;
	assign out.field_number  = field_q;
	assign out.sentence_type = type_q;
	assign out.checksum_text = cksum_q;

	// Match the stored name against the known names, first match wins.
	always_comb begin
		logic same;
		match_type = TYPE_UNKNOWN;
		for (int k = KNOWN_COUNT - 1; k >= 0; k--) begin
			same = (int'(KNOWN_LEN[k]) <= NAME_CHARS) &&
				(int'(name_len_q) == int'(KNOWN_LEN[k]));
			for (int i = 0; i < CMP_CHARS; i++) begin
				if ((i < int'(KNOWN_LEN[k])) &&
					(name_q[i] != KNOWN_TEXT[k][63 - 8 * i -: 8])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				match_type = 4'(k);
			end
		end
	end

	// Framing state machine.
	always_comb begin
		phase_d    = phase_q;
		name_len_d = name_len_q;
		field_d    = field_q;
		cksum_d    = cksum_q;
		name_wr    = 1'b0;
		ev_d       = EV_NONE;
		data_d     = 8'h00;
		type_d     = 4'd0;
		case (phase_q)
			PH_IDLE: begin
				if (head_entry.cls == CL_DOLLAR) begin
					name_len_d = '0;
					field_d    = '0;
					cksum_d    = '0;
					phase_d    = PH_BODY;
					ev_d       = EV_START;
				end else begin
					ev_d = EV_STRAY;
				end
			end
			PH_BODY: begin
				case (head_entry.cls)
					CL_DOLLAR: begin
						name_len_d = '0;
						field_d    = '0;
						cksum_d    = '0;
						ev_d       = EV_RESTART;
					end
					CL_STAR: begin
						phase_d = PH_CK0;
					end
					CL_CR, CL_LF: begin
						phase_d = PH_IDLE;
						ev_d    = EV_DROP;
					end
					CL_COMMA: begin
						if (field_q < 5'(FIELD_TOP)) begin
							field_d = field_q + 5'd1;
						end
						ev_d = EV_SEP;
					end
					default: begin
						if (field_q == 5'd0) begin
							name_wr = (int'(name_len_q) < NAME_CHARS);
							if (int'(name_len_q) <= NAME_CHARS) begin
								name_len_d = name_len_q + 1'b1;
							end
						end
						ev_d   = EV_BYTE;
						data_d = head_entry.data;
					end
				endcase
			end
			PH_CK0: begin
				cksum_d = {head_entry.data, cksum_q[7:0]};
				phase_d = PH_CK1;
			end
			PH_CK1: begin
				cksum_d = {cksum_q[15:8], head_entry.data};
				phase_d = PH_CR;
			end
			PH_CR, PH_LF: begin
				if (((phase_q == PH_CR) && (head_entry.cls == CL_CR)) ||
					((phase_q == PH_LF) && (head_entry.cls == CL_LF))) begin
					if (phase_q == PH_CR) begin
						phase_d = PH_LF;
					end else begin
						phase_d = PH_IDLE;
						ev_d    = EV_ACCEPT;
						type_d  = match_type;
					end
				end else if (head_entry.cls == CL_DOLLAR) begin
					name_len_d = '0;
					field_d    = '0;
					cksum_d    = '0;
					phase_d    = PH_BODY;
					ev_d       = EV_RESTART;
				end else begin
					phase_d = PH_IDLE;
					ev_d    = EV_DROP;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Name character storage.
	always_ff @(posedge clk) begin
		if (pop && name_wr) begin
			name_q[name_len_q[NI-1:0]] <= head_entry.data;
		end
	end

	// Sentence state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			name_len_q  <= '0;
			field_q     <= '0;
			cksum_q     <= '0;
			out_valid_q <= 1'b0;
			ev_q        <= EV_NONE;
			data_q      <= '0;
			type_q      <= '0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				name_len_q  <= name_len_d;
				field_q     <= field_d;
				cksum_q     <= cksum_d;
				ev_q        <= ev_d;
				data_q      <= data_d;
				type_q      <= type_d;
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/nmea_sentence_deframer_unit.sv -----
// Results: a byte accepted at the input is stored in the queue and then in the
// result register of the back; one result per byte, always.
// Throughput: one byte per cycle while the receiver takes results; a
// two-entry queue and the result register decouple the sides.
// Reset: arst_n clears the frame phase, name length, field counter,
// checksum, queue and result valid; the unit then waits for a '$'.
// ----------------------------------------------------------------------------
// NMEA sentence deframer
// Byte-serial NMEA 0183 deframer: classifies bytes, frames sentences, splits
// fields and names the sentence type when a sentence is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_deframer_unit #(
	parameter int MAX_FIELDS = 32,
	parameter int NAME_CHARS = 7
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nsd_in_if.sink    in,
	nsd_out_if.source out
);
	import nsd_pkg::*;

	logic       push;
	logic       pop;
	logic       q_full;
	logic       head_valid;
	nsd_entry_t push_entry;
	nsd_entry_t head_entry;

	// Byte intake and classification.
	nsd_front u_front (
		.in         (in),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decoupling queue.
	nsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Framing state machine and result register.
	nsd_back #(
		.MAX_FIELDS (MAX_FIELDS),
		.NAME_CHARS (NAME_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out        (out)
	);

endmodule

`default_nettype wire

// ----- dv/nmea_sentence_deframer_unit_test.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence deframer unit test
// Feeds raw bytes into the deframer and checks every result item against a
// cycle-free model of the framing. A short directed sequence runs first:
// stray bytes, empty and known names, restarts and drops in the body and line-end phases.
// Random sentences follow, mostly well formed with known, near-miss, long
// and empty names, some with enough fields to saturate the counter, a share
// of them corrupted, and some noise. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_deframer_unit_test;
	import nsd_pkg::*;

	localparam int MAX_FIELDS = 32;
	localparam int NAME_CHARS = 7;
	localparam int FIELD_TOP = (MAX_FIELDS - 1 < 31) ? MAX_FIELDS - 1 : 31;
	localparam int STALL_LIMIT = 4000;
	localparam int BYTES_PER_PHASE = 340;

	// One result item as the output channel carries it.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [4:0]  field;
		logic [3:0]  stype;
		logic [15:0] cks;
	} frame_result_t;

	// One directed byte, with its result typed in where it is obvious.
	typedef struct packed {
		logic [7:0]    ch;
		logic          fixed;
		frame_result_t want;
	} directed_row_t;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_BODY,
		PH_CK_HI,
		PH_CK_LO,
		PH_CR,
		PH_LF
	} frame_phase_e;

	localparam frame_result_t NO_FIXED = '0;

	localparam directed_row_t DIRECTED_ROWS [32] = '{
		'{8'h00, 1'b1, '{EV_STRAY, 8'h00, 5'd0, 4'd0, 16'h0000}},
		'{CH_DOLLAR, 1'b1, '{EV_START, 8'h00, 5'd0, 4'd0, 16'h0000}},
		'{CH_COMMA, 1'b1, '{EV_SEP, 8'h00, 5'd1, 4'd0, 16'h0000}},
		'{CH_DOLLAR, 1'b1, '{EV_RESTART, 8'h00, 5'd0, 4'd0, 16'h0000}},
		'{CH_STAR, 1'b0, NO_FIXED},
		'{CH_DOLLAR, 1'b0, NO_FIXED},
		'{8'hFF, 1'b0, NO_FIXED},
		'{CH_CR, 1'b0, NO_FIXED},
		'{CH_LF, 1'b1, '{EV_ACCEPT, 8'h00, 5'd0, TYPE_UNKNOWN, 16'h24FF}},
		'{CH_DOLLAR, 1'b0, NO_FIXED},
		'{CH_LF, 1'b1, '{EV_DROP, 8'h00, 5'd0, 4'd0, 16'h0000}},
		'{CH_DOLLAR, 1'b0, NO_FIXED},
		'{8'h47, 1'b1, '{EV_BYTE, 8'h47, 5'd0, 4'd0, 16'h0000}},
		'{8'h50, 1'b0, NO_FIXED},
		'{8'h52, 1'b0, NO_FIXED},
		'{8'h4D, 1'b0, NO_FIXED},
		'{8'h43, 1'b0, NO_FIXED},
		'{CH_STAR, 1'b0, NO_FIXED},
		'{8'h31, 1'b0, NO_FIXED},
		'{8'h32, 1'b0, NO_FIXED},
		'{CH_CR, 1'b0, NO_FIXED},
		'{CH_LF, 1'b1, '{EV_ACCEPT, 8'h00, 5'd0, 4'd5, 16'h3132}},
		'{CH_DOLLAR, 1'b0, NO_FIXED},
		'{CH_STAR, 1'b0, NO_FIXED},
		'{8'h30, 1'b0, NO_FIXED},
		'{8'h30, 1'b0, NO_FIXED},
		'{CH_DOLLAR, 1'b1, '{EV_RESTART, 8'h00, 5'd0, 4'd0, 16'h0000}},
		'{CH_STAR, 1'b0, NO_FIXED},
		'{8'h41, 1'b0, NO_FIXED},
		'{8'h42, 1'b0, NO_FIXED},
		'{CH_CR, 1'b0, NO_FIXED},
		'{8'hFF, 1'b1, '{EV_DROP, 8'h00, 5'd0, 4'd0, 16'h4142}}
	};

	logic clk = 1'b0;
	logic arst_n;

	nsd_in_if  in_ch ();
	nsd_out_if out_ch ();

	nmea_sentence_deframer_unit #(
		.MAX_FIELDS(MAX_FIELDS),
		.NAME_CHARS(NAME_CHARS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch)
	);

	// Known sentence names, type code is the position in this list.
	string known_names [14] = '{
		"GPGGA", "GPGLL", "GPGSA", "GPGSV", "GPMSS", "GPRMC", "GPVTG",
		"GPZDA", "PSRF140", "PSRF150", "PSRF151", "PSRF152", "PSRF154",
		"PSRF155"
	};
	string near_chars = "GPSRFAMCV0145";

	// Framing state tracked alongside the block.
	frame_phase_e tracked_phase;
	logic [7:0]   name_seen [NAME_CHARS];
	int           name_len;
	logic [4:0]   field_idx;
	logic [15:0]  cks_seen;

	frame_result_t pending_events [$];
	logic [7:0]    sentence_bytes [$];
	int            mismatch_count = 0;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            stall_cycles;

	always #10 clk = ~clk;

	function automatic void clear_sentence();
		for (int i = 0; i < NAME_CHARS; i++) begin
			name_seen[i] = 8'h00;
		end
		name_len = 0;
		field_idx = '0;
		cks_seen = '0;
	endfunction

	// Appends one byte to the planned sentence.
	function automatic void add_byte(input logic [7:0] b);
		sentence_bytes.insert(sentence_bytes.size(), b);
	endfunction

	// Type code of the stored name; too long or empty names are unknown.
	function automatic logic [3:0] sentence_code();
		logic same;
		if (name_len > NAME_CHARS)
			return TYPE_UNKNOWN;
		for (int k = 0; k < KNOWN_COUNT; k++) begin
			if (known_names[k].len() <= NAME_CHARS && known_names[k].len() == name_len) begin
				same = 1'b1;
				for (int i = 0; i < name_len; i++) begin
					if (name_seen[i] != known_names[k][i])
						same = 1'b0;
				end
				if (same)
					return 4'(k);
			end
		end
		return TYPE_UNKNOWN;
	endfunction

	// Advances the tracked framing state by one byte and returns its result.
	function automatic frame_result_t deframed_result(input logic [7:0] b);
		frame_result_t r;
		r = '0;
		r.kind = EV_NONE;
		case (tracked_phase)
			PH_WAIT: begin
				if (b == CH_DOLLAR) begin
					clear_sentence();
					tracked_phase = PH_BODY;
					r.kind = EV_START;
				end else begin
					r.kind = EV_STRAY;
				end
			end
			PH_BODY: begin
				if (b == CH_DOLLAR) begin
					clear_sentence();
					r.kind = EV_RESTART;
				end else if (b == CH_STAR) begin
					tracked_phase = PH_CK_HI;
				end else if (b == CH_CR || b == CH_LF) begin
					tracked_phase = PH_WAIT;
					r.kind = EV_DROP;
				end else if (b == CH_COMMA) begin
					if (field_idx < FIELD_TOP)
						field_idx++;
					r.kind = EV_SEP;
				end else begin
					// Name bytes past the store only mark the name too long.
					if (field_idx == 0) begin
						if (name_len < NAME_CHARS)
							name_seen[name_len] = b;
						if (name_len <= NAME_CHARS)
							name_len++;
					end
					r.kind = EV_BYTE;
					r.data = b;
				end
			end
			PH_CK_HI: begin
				cks_seen[15:8] = b;
				tracked_phase = PH_CK_LO;
			end
			PH_CK_LO: begin
				cks_seen[7:0] = b;
				tracked_phase = PH_CR;
			end
			PH_CR: begin
				if (b == CH_CR) begin
					tracked_phase = PH_LF;
				end else if (b == CH_DOLLAR) begin
					clear_sentence();
					tracked_phase = PH_BODY;
					r.kind = EV_RESTART;
				end else begin
					tracked_phase = PH_WAIT;
					r.kind = EV_DROP;
				end
			end
			PH_LF: begin
				if (b == CH_LF) begin
					r.stype = sentence_code();
					tracked_phase = PH_WAIT;
					r.kind = EV_ACCEPT;
				end else if (b == CH_DOLLAR) begin
					clear_sentence();
					tracked_phase = PH_BODY;
					r.kind = EV_RESTART;
				end else begin
					tracked_phase = PH_WAIT;
					r.kind = EV_DROP;
				end
			end
			default: begin
				tracked_phase = PH_WAIT;
			end
		endcase
		r.field = field_idx;
		r.cks = cks_seen;
		return r;
	endfunction

	// A byte that is not a framing character.
	function automatic logic [7:0] body_char();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(255));
		end while (b == CH_DOLLAR || b == CH_STAR || b == CH_CR || b == CH_LF
			|| b == CH_COMMA);
		return b;
	endfunction

	function automatic logic [7:0] framing_char();
		case ($urandom_range(5))
			0: return CH_DOLLAR;
			1: return CH_STAR;
			2: return CH_CR;
			3: return CH_LF;
			4: return CH_COMMA;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Fills sentence_bytes with noise, or a sentence that may be corrupted.
	task automatic plan_sentence();
		int roll;
		int count;
		int len;
		string nm;
		sentence_bytes.delete();
		roll = $urandom_range(99);
		if (roll < 12) begin
			count = $urandom_range(1, 4);
			repeat (count) add_byte(8'($urandom_range(255)));
			return;
		end
		add_byte(CH_DOLLAR);
		roll = $urandom_range(99);
		if (roll < 60) begin
			nm = known_names[$urandom_range(KNOWN_COUNT - 1)];
			for (int i = 0; i < nm.len(); i++) add_byte(nm[i]);
		end else if (roll < 70) begin
			// Empty name.
		end else if (roll < 85) begin
			len = $urandom_range(NAME_CHARS + 1, NAME_CHARS + 3);
			repeat (len) add_byte(body_char());
		end else begin
			len = $urandom_range(1, NAME_CHARS);
			repeat (len) add_byte(near_chars[$urandom_range(12)]);
		end
		// Occasionally enough fields to pin the counter at its top.
		count = ($urandom_range(99) < 6) ? $urandom_range(30, 40) : $urandom_range(0, 6);
		repeat (count) begin
			add_byte(CH_COMMA);
			len = $urandom_range(0, 5);
			repeat (len) add_byte(body_char());
		end
		add_byte(CH_STAR);
		add_byte(8'($urandom_range(255)));
		add_byte(8'($urandom_range(255)));
		add_byte(CH_CR);
		add_byte(CH_LF);
		if ($urandom_range(99) < 20)
			sentence_bytes[$urandom_range(1, sentence_bytes.size() - 1)] = framing_char();
	endtask

	// Offers one byte and records the result it must cause once accepted.
	task automatic send_item(input logic [7:0] b, input logic fixed,
		input frame_result_t fixed_want);
		frame_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.byte_in = b;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = deframed_result(b);
		pending_events.insert(pending_events.size(), fixed ? fixed_want : predicted);
	endtask

	// Stops offering bytes until every outstanding result has come out.
	task automatic hold_until_drained();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string label, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	// Receiver stalls, changed at the falling edge.
	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each result item with the oldest outstanding expectation.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_events.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected nothing, actual event %0d",
					$time, out_ch.event_kind);
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", want.kind, out_ch.event_kind);
				check_field("data_byte", want.data, out_ch.data_byte);
				check_field("field_number", want.field, out_ch.field_number);
				check_field("sentence_type", want.stype, out_ch.sentence_type);
				check_field("checksum_text", want.cks, out_ch.checksum_text);
			end
		end
	end

	// Ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Reset, directed bytes, then three random phases with different stalls.
	initial begin
		int sent;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.byte_in = 8'h00;
		out_ch.ready = 1'b0;
		send_idle_pct = 37;
		recv_idle_pct = 77;
		stall_cycles = 0;
		tracked_phase = PH_WAIT;
		clear_sentence();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			send_item(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				plan_sentence();
				foreach (sentence_bytes[i]) send_item(sentence_bytes[i], 1'b0, NO_FIXED);
				sent += sentence_bytes.size();
			end
			hold_until_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_events.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
